// ===== sv/msr_pkg.sv =====
// Package for the matrix shape rasteriser: grid geometry, field widths,
// command kinds, controller states and the controller/datapath interface.
// Has no dependencies; every other file of the block refers to it.
`default_nettype none

package msr_pkg;

  localparam int GRID_WIDTH  = 8;
  localparam int GRID_HEIGHT = 8;
  localparam int MAX_RESULTS = 64;

  localparam int KIND_W   = 2;
  localparam int COORD_W  = 8;
  localparam int COLOUR_W = 8;
  localparam int PIX_W    = 6;

  // Coordinates that have passed the range check fit these widths.
  localparam int XW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int YW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int MW = (XW > YW) ? XW : YW;

  // Bresenham error term, signed.
  localparam int ERR_W = MW + 3;

  // Width used to form the strip index before it is masked to PIX_W bits.
  localparam int IDX_W = 16;

  localparam int CNT_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINE = 2'd0,
    KIND_RECT = 2'd1,
    KIND_BOX  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_FAULT
  } state_e;

  typedef struct packed {
    logic load;   // capture a new command and set up its first line
    logic step;   // emit the current pixel and advance
    logic fault;  // emit the out-of-range result
  } dp_cmd_t;

  typedef struct packed {
    logic kind_none; // incoming command has the unused kind
    logic oor;       // incoming command has a coordinate outside the grid
    logic line_end;  // current pixel is the end point of the current line
    logic last_seg;  // current line is the final one of the command
    logic at_cap;    // current pixel would be the final result allowed
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/msr_ctrl.sv =====
// Controller state machine of the matrix shape rasteriser.
// Depends on msr_pkg; drives commands to msr_datapath from its status.
`default_nettype none

module msr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire msr_pkg::dp_stat_t stat_i,
  output msr_pkg::dp_cmd_t       cmd_o
);

  msr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      msr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && !stat_i.kind_none) begin
          if (stat_i.oor) begin
            state_d = msr_pkg::ST_FAULT;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = msr_pkg::ST_DRAW;
          end
        end
      end
      msr_pkg::ST_DRAW: begin
        if (stat_i.out_free) begin
          cmd_o.step = 1'b1;
          if ((stat_i.line_end && stat_i.last_seg) || stat_i.at_cap) begin
            state_d = msr_pkg::ST_IDLE;
          end
        end
      end
      msr_pkg::ST_FAULT: begin
        if (stat_i.out_free) begin
          cmd_o.fault = 1'b1;
          state_d     = msr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = msr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/msr_datapath.sv =====
// Datapath of the matrix shape rasteriser: command registers, segment
// sequencing, Bresenham stepper, strip index and output register.
// Depends on msr_pkg; commanded by msr_ctrl.
`default_nettype none

module msr_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [msr_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [msr_pkg::COORD_W-1:0]    start_x_i,
  input  wire logic [msr_pkg::COORD_W-1:0]    start_y_i,
  input  wire logic [msr_pkg::COORD_W-1:0]    end_x_i,
  input  wire logic [msr_pkg::COORD_W-1:0]    end_y_i,
  input  wire logic [msr_pkg::COLOUR_W-1:0]   red_i,
  input  wire logic [msr_pkg::COLOUR_W-1:0]   green_i,
  input  wire logic [msr_pkg::COLOUR_W-1:0]   blue_i,
  input  wire msr_pkg::dp_cmd_t               cmd_i,
  output msr_pkg::dp_stat_t                   stat_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [msr_pkg::PIX_W-1:0]           pixel_index_o,
  output logic [msr_pkg::COLOUR_W-1:0]        pixel_red_o,
  output logic [msr_pkg::COLOUR_W-1:0]        pixel_green_o,
  output logic [msr_pkg::COLOUR_W-1:0]        pixel_blue_o,
  output logic                                out_of_range_o,
  output logic                                last_o
);

  localparam int XW    = msr_pkg::XW;
  localparam int YW    = msr_pkg::YW;
  localparam int ERR_W = msr_pkg::ERR_W;
  localparam int IDX_W = msr_pkg::IDX_W;
  localparam int CW    = msr_pkg::COLOUR_W;

  // Command registers.
  msr_pkg::kind_e  kind_q;
  logic [XW-1:0]   sx_q, ex_q, xmax_q, col_q;
  logic [YW-1:0]   sy_q, ey_q;
  logic [1:0]      seg_q;
  logic [CW-1:0]   red_q, green_q, blue_q;

  // Line stepper registers.
  logic [XW-1:0]           cur_x_q, tgt_x_q, dx_q;
  logic [YW-1:0]           cur_y_q, tgt_y_q, dy_q;
  logic                    neg_x_q, neg_y_q;
  logic signed [ERR_W-1:0] err_q;
  logic [msr_pkg::CNT_W-1:0] cnt_q;

  // Output register.
  logic                    out_valid_q;
  logic [msr_pkg::PIX_W-1:0] idx_q;
  logic [CW-1:0]           ored_q, ogreen_q, oblue_q;
  logic                    oor_q, last_q;

  // Source of the next line.
  msr_pkg::kind_e  src_kind;
  logic [XW-1:0]   src_sx, src_ex, col_n, xmax_n;
  logic [YW-1:0]   src_sy, src_ey;
  logic [1:0]      seg_n;
  logic [XW-1:0]   p0x, p1x, dx_n;
  logic [YW-1:0]   p0y, p1y, dy_n;
  logic signed [ERR_W-1:0] err_n;

  logic                    line_end, last_seg, at_cap, reload;
  logic signed [ERR_W:0]   e2, dx_s, dy_s;
  logic                    move_x, move_y;
  logic signed [ERR_W-1:0] err_step;
  logic [IDX_W-1:0]        idx_full;

  assign line_end = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
  assign at_cap   = (cnt_q == msr_pkg::CNT_W'(msr_pkg::MAX_RESULTS - 1));

  always_comb begin
    case (kind_q)
      msr_pkg::KIND_RECT: last_seg = (seg_q == 2'd3);
      msr_pkg::KIND_BOX:  last_seg = (col_q == xmax_q);
      default:            last_seg = 1'b1;
    endcase
  end

  assign reload = cmd_i.load || (cmd_i.step && line_end && !last_seg);

  // Choose the command fields: fresh from the inputs on load, else the stored ones.
  always_comb begin
    if (cmd_i.load) begin
      src_kind = msr_pkg::kind_e'(kind_i);
      src_sx   = start_x_i[XW-1:0];
      src_ex   = end_x_i[XW-1:0];
      src_sy   = start_y_i[YW-1:0];
      src_ey   = end_y_i[YW-1:0];
      seg_n    = 2'd0;
      col_n    = (src_sx < src_ex) ? src_sx : src_ex;
      xmax_n   = (src_sx < src_ex) ? src_ex : src_sx;
    end else begin
      src_kind = kind_q;
      src_sx   = sx_q;
      src_ex   = ex_q;
      src_sy   = sy_q;
      src_ey   = ey_q;
      seg_n    = seg_q + 2'd1;
      col_n    = col_q + XW'(1);
      xmax_n   = xmax_q;
    end
  end

  // End points of the next line.
  always_comb begin
    p0x = src_sx;
    p0y = src_sy;
    p1x = src_ex;
    p1y = src_ey;
    case (src_kind)
      msr_pkg::KIND_RECT: begin
        case (seg_n)
          2'd0: begin
            p0x = src_sx; p0y = src_sy; p1x = src_ex; p1y = src_sy;
          end
          2'd1: begin
            p0x = src_ex; p0y = src_sy; p1x = src_ex; p1y = src_ey;
          end
          2'd2: begin
            p0x = src_ex; p0y = src_ey; p1x = src_sx; p1y = src_ey;
          end
          default: begin
            p0x = src_sx; p0y = src_ey; p1x = src_sx; p1y = src_sy;
          end
        endcase
      end
      msr_pkg::KIND_BOX: begin
        p0x = col_n; p0y = src_sy; p1x = col_n; p1y = src_ey;
      end
      default: begin
        p0x = src_sx; p0y = src_sy; p1x = src_ex; p1y = src_ey;
      end
    endcase
    dx_n  = (p1x >= p0x) ? (p1x - p0x) : (p0x - p1x);
    dy_n  = (p1y >= p0y) ? (p1y - p0y) : (p0y - p1y);
    err_n = ERR_W'(dx_n) - ERR_W'(dy_n);
  end

  // One Bresenham step: both decisions use the error before the update.
  always_comb begin
    e2       = {err_q, 1'b0};
    dx_s     = (ERR_W + 1)'(dx_q);
    dy_s     = (ERR_W + 1)'(dy_q);
    move_x   = (e2 > -dy_s);
    move_y   = (e2 < dx_s);
    err_step = err_q - (move_x ? ERR_W'(dy_q) : '0) + (move_y ? ERR_W'(dx_q) : '0);
  end

  // Serpentine index: even rows run reversed, odd rows forward.
  always_comb begin
    if (cur_y_q[0]) begin
      idx_full = IDX_W'(cur_y_q) * IDX_W'(msr_pkg::GRID_WIDTH) + IDX_W'(cur_x_q);
    end else begin
      idx_full = IDX_W'(cur_y_q) * IDX_W'(msr_pkg::GRID_WIDTH)
               + IDX_W'(msr_pkg::GRID_WIDTH - 1) - IDX_W'(cur_x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= src_kind;
      sx_q    <= src_sx;
      ex_q    <= src_ex;
      sy_q    <= src_sy;
      ey_q    <= src_ey;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    if (reload) begin
      seg_q   <= seg_n;
      col_q   <= col_n;
      xmax_q  <= xmax_n;
      cur_x_q <= p0x;
      cur_y_q <= p0y;
      tgt_x_q <= p1x;
      tgt_y_q <= p1y;
      dx_q    <= dx_n;
      dy_q    <= dy_n;
      neg_x_q <= !(p0x < p1x);
      neg_y_q <= !(p0y < p1y);
      err_q   <= err_n;
    end else if (cmd_i.step) begin
      err_q <= err_step;
      if (move_x) begin
        cur_x_q <= neg_x_q ? (cur_x_q - XW'(1)) : (cur_x_q + XW'(1));
      end
      if (move_y) begin
        cur_y_q <= neg_y_q ? (cur_y_q - YW'(1)) : (cur_y_q + YW'(1));
      end
    end
    if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + msr_pkg::CNT_W'(1);
    end
    if (cmd_i.step) begin
      idx_q    <= idx_full[msr_pkg::PIX_W-1:0];
      ored_q   <= red_q;
      ogreen_q <= green_q;
      oblue_q  <= blue_q;
      oor_q    <= 1'b0;
      last_q   <= (line_end && last_seg) || at_cap;
    end else if (cmd_i.fault) begin
      idx_q    <= '0;
      ored_q   <= '0;
      ogreen_q <= '0;
      oblue_q  <= '0;
      oor_q    <= 1'b1;
      last_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step || cmd_i.fault) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.kind_none = (msr_pkg::kind_e'(kind_i) == msr_pkg::KIND_NONE);
  assign stat_o.oor       = (start_x_i >= msr_pkg::COORD_W'(msr_pkg::GRID_WIDTH))
                         || (end_x_i   >= msr_pkg::COORD_W'(msr_pkg::GRID_WIDTH))
                         || (start_y_i >= msr_pkg::COORD_W'(msr_pkg::GRID_HEIGHT))
                         || (end_y_i   >= msr_pkg::COORD_W'(msr_pkg::GRID_HEIGHT));
  assign stat_o.line_end  = line_end;
  assign stat_o.last_seg  = last_seg;
  assign stat_o.at_cap    = at_cap;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign pixel_index_o  = idx_q;
  assign pixel_red_o    = ored_q;
  assign pixel_green_o  = ogreen_q;
  assign pixel_blue_o   = oblue_q;
  assign out_of_range_o = oor_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ===== sv/matrix_shape_rasterizer.sv =====
// Top level of the matrix shape rasteriser: joins the controller and datapath.
// Depends on msr_pkg, msr_ctrl and msr_datapath.
//
// Usage. The input channel takes one drawing command per item: kind, two corner
// points and a colour. An item is accepted at a rising edge where in_valid_i is
// high and in_stall_o is low. The output channel gives one item per pixel, as a
// serpentine strip index with the colour; last_o marks the final item of a
// command. A command with any coordinate outside the grid gives a single item
// with out_of_range_o and last_o set and zero index and colour. The unused kind
// is accepted and gives no items at all.
// Timing. After a command is accepted, the Bresenham stepper puts its first
// pixel in the output register when it is free, then makes one pixel per cycle
// while the output is not stalled, moving from one line of a rectangle or box
// to the next with no gap. in_stall_o stays high while a command is drawn, and
// the next command is taken in the cycle after the last pixel is produced.
// Only one command is in work at a time.
// Stalls. When out_stall_i holds the output register full, the stepper waits and
// the shown item stays unchanged. After reset the block is idle, with no output
// item pending, and accepts a command at once.
`default_nettype none

module matrix_shape_rasterizer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [msr_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [msr_pkg::COORD_W-1:0]  start_x_i,
  input  wire logic [msr_pkg::COORD_W-1:0]  start_y_i,
  input  wire logic [msr_pkg::COORD_W-1:0]  end_x_i,
  input  wire logic [msr_pkg::COORD_W-1:0]  end_y_i,
  input  wire logic [msr_pkg::COLOUR_W-1:0] red_i,
  input  wire logic [msr_pkg::COLOUR_W-1:0] green_i,
  input  wire logic [msr_pkg::COLOUR_W-1:0] blue_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [msr_pkg::PIX_W-1:0]         pixel_index_o,
  output logic [msr_pkg::COLOUR_W-1:0]      pixel_red_o,
  output logic [msr_pkg::COLOUR_W-1:0]      pixel_green_o,
  output logic [msr_pkg::COLOUR_W-1:0]      pixel_blue_o,
  output logic                              out_of_range_o,
  output logic                              last_o
);

  // Commands from the controller and status back from the datapath.
  msr_pkg::dp_cmd_t  cmd;
  msr_pkg::dp_stat_t stat;

  msr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  msr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (kind_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_index_o  (pixel_index_o),
    .pixel_red_o    (pixel_red_o),
    .pixel_green_o  (pixel_green_o),
    .pixel_blue_o   (pixel_blue_o),
    .out_of_range_o (out_of_range_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ===== sim/tb_matrix_shape_rasterizer.sv =====
// Self-checking testbench for matrix_shape_rasterizer: drives drawing commands,
// predicts every pixel item with its own Bresenham rasteriser and checks each output.
// Depends on msr_pkg and matrix_shape_rasterizer.
`default_nettype none

module tb_matrix_shape_rasterizer;

  // Longest run of cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 188;
  localparam int MAX_WAIT       = 10;

  typedef struct packed {
    logic [msr_pkg::KIND_W-1:0]   kind;
    logic [msr_pkg::COORD_W-1:0]  sx;
    logic [msr_pkg::COORD_W-1:0]  sy;
    logic [msr_pkg::COORD_W-1:0]  ex;
    logic [msr_pkg::COORD_W-1:0]  ey;
    logic [msr_pkg::COLOUR_W-1:0] red;
    logic [msr_pkg::COLOUR_W-1:0] green;
    logic [msr_pkg::COLOUR_W-1:0] blue;
  } shape_cmd_t;

  typedef struct packed {
    logic [msr_pkg::PIX_W-1:0]    index;
    logic [msr_pkg::COLOUR_W-1:0] red;
    logic [msr_pkg::COLOUR_W-1:0] green;
    logic [msr_pkg::COLOUR_W-1:0] blue;
    logic                         oor;
    logic                         last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Input channel, driven at the falling edge.
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  shape_cmd_t                   driven_cmd = '0;

  // Output channel.
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [msr_pkg::PIX_W-1:0]    pixel_index;
  logic [msr_pkg::COLOUR_W-1:0] pixel_red;
  logic [msr_pkg::COLOUR_W-1:0] pixel_green;
  logic [msr_pkg::COLOUR_W-1:0] pixel_blue;
  logic                         out_of_range;
  logic                         last;

  shape_cmd_t pending_cmds[$];     // commands not yet presented to the block
  pixel_t     expected_pixels[$];  // pixel items predicted but not yet seen
  pixel_t     command_pixels[$];   // pixels of the command being rasterised

  logic [msr_pkg::COLOUR_W-1:0] paint_r, paint_g, paint_b;

  logic in_took  = 1'b0;  // an input item was accepted at the last rising edge
  logic out_took = 1'b0;  // an output item was accepted at the last rising edge
  int   in_gap   = 0;     // idle cycles still to insert before the next command
  int   out_wait = 0;     // further cycles for which the output stays stalled
  int   issued   = 0;
  int   received = 0;
  int   errors   = 0;
  int   quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  matrix_shape_rasterizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (driven_cmd.kind),
    .start_x_i      (driven_cmd.sx),
    .start_y_i      (driven_cmd.sy),
    .end_x_i        (driven_cmd.ex),
    .end_y_i        (driven_cmd.ey),
    .red_i          (driven_cmd.red),
    .green_i        (driven_cmd.green),
    .blue_i         (driven_cmd.blue),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_index_o  (pixel_index),
    .pixel_red_o    (pixel_red),
    .pixel_green_o  (pixel_green),
    .pixel_blue_o   (pixel_blue),
    .out_of_range_o (out_of_range),
    .last_o         (last)
  );

  // ---------------------------------------------------------------------------
  // Pixel predictor
  // ---------------------------------------------------------------------------

  // Maps a grid position onto the serpentine strip: even rows run right to left,
  // odd rows left to right. Pixels beyond the per-command cap are dropped.
  task automatic plot_pixel(input int x, input int y);
    int     idx;
    pixel_t p;
    if (y % 2 == 1) begin
      idx = y * msr_pkg::GRID_WIDTH + x;
    end else begin
      idx = y * msr_pkg::GRID_WIDTH + (msr_pkg::GRID_WIDTH - 1 - x);
    end
    p       = '0;
    p.index = idx[msr_pkg::PIX_W-1:0];
    p.red   = paint_r;
    p.green = paint_g;
    p.blue  = paint_b;
    if (command_pixels.size() < msr_pkg::MAX_RESULTS) begin
      command_pixels.push_back(p);
    end
  endtask

  // Integer Bresenham walk from (x0,y0) to (x1,y1), both end points included.
  task automatic trace_segment(input int x0, input int y0, input int x1, input int y1);
    int dx, dy, sx, sy, err, e2, x, y;
    bit done;
    dx   = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy   = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx   = (x0 < x1) ? 1 : -1;
    sy   = (y0 < y1) ? 1 : -1;
    err  = dx - dy;
    x    = x0;
    y    = y0;
    done = 1'b0;
    while (!done) begin
      plot_pixel(x, y);
      if (x == x1 && y == y1) begin
        done = 1'b1;
      end else begin
        e2 = 2 * err;
        if (e2 > -dy) begin
          err = err - dy;
          x   = x + sx;
        end
        if (e2 < dx) begin
          err = err + dx;
          y   = y + sy;
        end
      end
    end
  endtask

  // Works out every pixel item of one accepted command and queues them in order,
  // with last set on the final one. The unused kind yields nothing at all.
  task automatic rasterise_command(input shape_cmd_t c);
    int     lo, hi, col, i, cx0, cy0, cx1, cy1;
    pixel_t p;
    command_pixels.delete();
    paint_r = c.red;
    paint_g = c.green;
    paint_b = c.blue;
    cx0 = int'(c.sx);
    cy0 = int'(c.sy);
    cx1 = int'(c.ex);
    cy1 = int'(c.ey);
    if (c.kind != msr_pkg::KIND_NONE) begin
      if (cx0 >= msr_pkg::GRID_WIDTH || cx1 >= msr_pkg::GRID_WIDTH ||
          cy0 >= msr_pkg::GRID_HEIGHT || cy1 >= msr_pkg::GRID_HEIGHT) begin
        p     = '0;
        p.oor = 1'b1;
        command_pixels.push_back(p);
      end else begin
        case (c.kind)
          msr_pkg::KIND_LINE: begin
            trace_segment(cx0, cy0, cx1, cy1);
          end
          msr_pkg::KIND_RECT: begin
            trace_segment(cx0, cy0, cx1, cy0);
            trace_segment(cx1, cy0, cx1, cy1);
            trace_segment(cx1, cy1, cx0, cy1);
            trace_segment(cx0, cy1, cx0, cy0);
          end
          default: begin
            lo = (cx0 < cx1) ? cx0 : cx1;
            hi = (cx0 < cx1) ? cx1 : cx0;
            for (col = lo; col <= hi; col++) begin
              trace_segment(col, cy0, col, cy1);
            end
          end
        endcase
      end
    end
    for (i = 0; i < command_pixels.size(); i++) begin
      p      = command_pixels[i];
      p.last = (i == command_pixels.size() - 1);
      expected_pixels.push_back(p);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  function automatic shape_cmd_t make_cmd(input logic [msr_pkg::KIND_W-1:0] kind,
                                          input int sx, input int sy,
                                          input int ex, input int ey,
                                          input int r, input int g, input int b);
    shape_cmd_t c;
    c.kind  = kind;
    c.sx    = sx[msr_pkg::COORD_W-1:0];
    c.sy    = sy[msr_pkg::COORD_W-1:0];
    c.ex    = ex[msr_pkg::COORD_W-1:0];
    c.ey    = ey[msr_pkg::COORD_W-1:0];
    c.red   = r[msr_pkg::COLOUR_W-1:0];
    c.green = g[msr_pkg::COLOUR_W-1:0];
    c.blue  = b[msr_pkg::COLOUR_W-1:0];
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued commands at the falling edge. After each command it
  // draws an idle gap; every fourth run of 16 commands goes without gaps so that
  // back-to-back items are exercised as well.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!in_valid || in_took) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_cmds.size() != 0) begin
        driven_cmd <= pending_cmds.pop_front();
        in_valid   <= 1'b1;
        in_gap     <= ((issued % 64) < 16) ? 0 : int'($urandom_range(0, MAX_WAIT));
        issued     <= issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure: after each accepted pixel item a fresh stall length is
  // drawn, with stall-free stretches in between.
  always @(negedge clk_i) begin : stall_gen
    int w;
    if (out_took) begin
      w         = ((received % 100) < 25) ? 0 : int'($urandom_range(0, MAX_WAIT));
      out_stall <= (w != 0);
      out_wait  <= (w != 0) ? w - 1 : 0;
    end else if (out_wait != 0) begin
      out_stall <= 1'b1;
      out_wait  <= out_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, checks an accepted pixel item against the
  // oldest prediction, then predicts the pixels of a command accepted at the
  // same edge. The block registers its first pixel from its draw state, entered
  // on acceptance, so the item checked here always belongs to an earlier command.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    pixel_t want;
    in_took  <= in_valid && !in_stall;
    out_took <= out_valid && !out_stall;
    if (rst_ni && out_valid && !out_stall) begin
      received <= received + 1;
      if (expected_pixels.size() == 0) begin
        $error("pixel item with nothing expected: index %0d oor %0d",
               pixel_index, out_of_range);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_index", int'(want.index), int'(pixel_index));
        check_field("pixel_red", int'(want.red), int'(pixel_red));
        check_field("pixel_green", int'(want.green), int'(pixel_green));
        check_field("pixel_blue", int'(want.blue), int'(pixel_blue));
        check_field("out_of_range", int'(want.oor), int'(out_of_range));
        check_field("last", int'(want.last), int'(last));
      end
    end
    if (rst_ni && in_valid && !in_stall) begin
      rasterise_command(driven_cmd);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i, pick, which;
    shape_cmd_t c;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Lines: both diagonals, a single point, horizontal, vertical, steep and
    // shallow slopes in both directions, with extreme colours.
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 0, 0, 7, 7, 255, 255, 255));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 7, 0, 0, 7, 0, 0, 0));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 3, 3, 3, 3, 255, 0, 255));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 0, 5, 7, 5, 0, 255, 0));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 2, 7, 2, 0, 18, 52, 86));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 1, 0, 3, 7, 170, 85, 204));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 7, 6, 0, 4, 51, 102, 153));
    // Rectangle outlines: full grid, reversed corners, a single point and a flat
    // one, where the repeated corner pixels must come out again.
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_RECT, 0, 0, 7, 7, 1, 2, 3));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_RECT, 5, 2, 1, 6, 255, 128, 0));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_RECT, 4, 4, 4, 4, 9, 8, 7));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_RECT, 0, 3, 7, 3, 77, 66, 55));
    // Filled boxes: the full grid in both corner orders, a single row and a
    // single column.
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_BOX, 0, 0, 7, 7, 255, 255, 255));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_BOX, 7, 7, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_BOX, 6, 1, 2, 1, 200, 100, 50));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_BOX, 3, 0, 3, 7, 11, 22, 33));
    // Rejected commands: each start coordinate just past the grid, and bytes that
    // would be negative if read as signed.
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 8, 0, 0, 0, 255, 255, 255));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_RECT, 0, 8, 0, 0, 1, 1, 1));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_BOX, 0, 0, 255, 0, 2, 2, 2));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_LINE, 0, 0, 0, 128, 3, 3, 3));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_BOX, 200, 255, 129, 240, 4, 4, 4));
    // Unused kind: ignored whether the corners are inside the grid or not.
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_NONE, 1, 1, 6, 6, 5, 5, 5));
    pending_cmds.push_back(make_cmd(msr_pkg::KIND_NONE, 255, 255, 255, 255, 6, 6, 6));

    // Random commands: mostly well-formed shapes inside the grid with random
    // colours; some have one coordinate replaced by an arbitrary byte, a few
    // have all four arbitrary, and a few carry the unused kind.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = int'($urandom_range(0, 19));
      c.kind  = (pick == 0) ? msr_pkg::KIND_NONE :
                (pick < 7)  ? msr_pkg::KIND_LINE :
                (pick < 13) ? msr_pkg::KIND_RECT : msr_pkg::KIND_BOX;
      c.sx    = msr_pkg::COORD_W'($urandom_range(0, msr_pkg::GRID_WIDTH - 1));
      c.sy    = msr_pkg::COORD_W'($urandom_range(0, msr_pkg::GRID_HEIGHT - 1));
      c.ex    = msr_pkg::COORD_W'($urandom_range(0, msr_pkg::GRID_WIDTH - 1));
      c.ey    = msr_pkg::COORD_W'($urandom_range(0, msr_pkg::GRID_HEIGHT - 1));
      c.red   = msr_pkg::COLOUR_W'($urandom);
      c.green = msr_pkg::COLOUR_W'($urandom);
      c.blue  = msr_pkg::COLOUR_W'($urandom);
      pick = int'($urandom_range(0, 19));
      if (pick < 3) begin
        which = int'($urandom_range(0, 3));
        case (which)
          0:       c.sx = msr_pkg::COORD_W'($urandom);
          1:       c.sy = msr_pkg::COORD_W'($urandom);
          2:       c.ex = msr_pkg::COORD_W'($urandom);
          default: c.ey = msr_pkg::COORD_W'($urandom);
        endcase
      end else if (pick == 3) begin
        c.sx = msr_pkg::COORD_W'($urandom);
        c.sy = msr_pkg::COORD_W'($urandom);
        c.ex = msr_pkg::COORD_W'($urandom);
        c.ey = msr_pkg::COORD_W'($urandom);
      end
      pending_cmds.push_back(c);
    end

    // Wait until every command has been taken and every pixel has arrived, then
    // keep the clock running so that any stray item is seen.
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
